// File: src/rounded_corner_alpha_mask_macros.svh
// Assertion macros for the rounded corner alpha mask
`ifndef ROUNDED_CORNER_ALPHA_MASK_MACROS_SVH
`define ROUNDED_CORNER_ALPHA_MASK_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RCAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rcam_pkg.sv
// Types and constants for the rounded corner alpha mask pipeline
package rcam_pkg;

  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int RAD_W      = 8;
  localparam int CH_W       = 8;
  localparam int MAX_DIM    = 4096;
  localparam int SQ_STEPS   = 17;     // result bits of the distance square root
  localparam int DIV_STEPS  = CH_W;   // quotient bits of the colour rescale
  localparam int DV_STG     = DIV_STEPS;  // numerator stage plus divide stages before the output
  localparam int SQ_MAX     = 92320;  // ceiling of 256*sqrt(2*255*255)

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CORNER_RADIUS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t            pix;
    logic            corner;
    logic [CH_W-1:0] adx;
    logic [CH_W-1:0] ady;
  } geo_t;

  typedef struct packed {
    pix_t                pix;
    logic                corner;
    logic [16:0]         s;     // dx*dx + dy*dy
    logic [SQ_STEPS-1:0] q;     // partial root
    logic [17:0]         rem;   // partial remainder
  } sq_t;

  typedef struct packed {
    pix_t            pix;
    logic [CH_W-1:0] mask;
    logic            limit;
    logic            zero;
  } mk_t;

  typedef struct packed {
    mk_t              info;
    logic [2:0][15:0] acc;      // {remainder, numerator/quotient} per colour
  } dv_t;

endpackage

// File: src/rounded_corner_alpha_mask.sv
// Rounded corner alpha mask: top level, fully pipelined
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata[55:0]
//  out_    | out | out_tvalid/out_tready| out_tdata[31:0]
//  cfg_    | in  | cfg_we               | cfg_addr[1:0], cfg_wdata[12:0]
//
// One pixel per cycle sustained while out_tready does not stall; 29 register
// stages: geometry, square, 17 square-root digit stages, mask, numerator,
// 7 divide stages and the output register (holding the last divide step).
// rst_n is synchronous and clears all valid bits and the registers to
// 420 / 420 / 24. A stall on out_tready freezes every stage at once, so
// in_tready follows it directly; bubbles are not squeezed out.
`include "rounded_corner_alpha_mask_macros.svh"

module rounded_corner_alpha_mask
  import rcam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x[11:0], pos_y[23:12], in_blue[31:24], in_green[39:32],
  // in_red[47:40], in_alpha[55:48]
  input  logic [55:0]      in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_blue[7:0], out_green[15:8], out_red[23:16], out_alpha[31:24]
  output logic [31:0]      out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [DIM_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [RAD_W-1:0] corner_radius_r;

  logic               en;
  logic               geo_vld_r;
  geo_t               geo_r, geo_nxt;
  logic [SQ_STEPS:0]  sq_vld_r;
  sq_t                sq_r   [SQ_STEPS+1];
  sq_t                sq_nxt [SQ_STEPS+1];
  logic               mk_vld_r;
  mk_t                mk_r, mk_nxt;
  logic [DV_STG-1:0]  dv_vld_r;
  dv_t                dv_r   [DV_STG];
  dv_t                dv_nxt [DV_STG];
  logic               out_vld_r;
  pix_t               out_r, out_nxt;

  logic [SQ_STEPS+DV_STG+3:0] vld_all;
  logic                       root_ok;
  logic                       div_fits;

  // ---------------- helpers ----------------
  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] dig);
    logic [19:0] part;
    logic [19:0] trial;
    sq_t         nx;
    nx    = cur;
    part  = {cur.rem, dig};
    trial = {1'b0, cur.q, 2'b01};
    if (part >= trial) begin
      nx.rem = 18'(part - trial);
      nx.q   = {cur.q[SQ_STEPS-2:0], 1'b1};
    end else begin
      nx.rem = part[17:0];
      nx.q   = {cur.q[SQ_STEPS-2:0], 1'b0};
    end
    return nx;
  endfunction

  function automatic logic [15:0] div_step(logic [15:0] acc, logic [CH_W-1:0] den);
    logic [8:0] t;
    logic       qb;
    t  = acc[15:7];
    qb = (t >= {1'b0, den});
    if (qb) begin
      t = t - {1'b0, den};
    end
    return {t[7:0], acc[6:0], qb};
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= DIM_W'(420);
      frame_height_r  <= DIM_W'(420);
      corner_radius_r <= RAD_W'(24);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata;
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata;
        REG_CORNER_RADIUS: corner_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: corner geometry ----------------
  always_comb begin
    logic [POS_W-1:0] x, y;
    logic [DIM_W-1:0] w, h, minwh, half, r2, edge_len, xe, ye;
    logic             ok, left, right, top, bottom;
    logic [14:0]      dxs, dys;
    x  = in_tdata[11:0];
    y  = in_tdata[23:12];
    w  = (frame_width_r  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_r;
    h  = (frame_height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_r;
    xe = DIM_W'(x);
    ye = DIM_W'(y);
    ok = (w >= DIM_W'(2)) && (h >= DIM_W'(2)) && (xe < w) && (ye < h);
    minwh    = (w < h) ? w : h;
    half     = minwh >> 1;
    r2       = DIM_W'(corner_radius_r) + DIM_W'(2);
    edge_len = (r2 < half) ? r2 : half;
    left     = xe < edge_len;
    right    = xe >= (w - edge_len);
    top      = ye < edge_len;
    bottom   = ye >= (h - edge_len);
    dxs = left ? 15'(x) - 15'(corner_radius_r)
               : 15'(x) + 15'd1 - 15'(w) + 15'(corner_radius_r);
    dys = top  ? 15'(y) - 15'(corner_radius_r)
               : 15'(y) + 15'd1 - 15'(h) + 15'(corner_radius_r);
    geo_nxt.pix    = pix_t'(in_tdata[55:24]);
    geo_nxt.corner = ok && (left || right) && (top || bottom);
    // offsets stay within +-255 inside a corner box
    geo_nxt.adx    = dxs[14] ? 8'(-dxs) : dxs[7:0];
    geo_nxt.ady    = dys[14] ? 8'(-dys) : dys[7:0];
  end

  // ---------------- stage 2 and square-root digit stages ----------------
  always_comb begin
    logic [33:0] v;
    sq_nxt[0].pix    = geo_r.pix;
    sq_nxt[0].corner = geo_r.corner;
    sq_nxt[0].s      = 17'(16'(geo_r.adx * geo_r.adx)) + 17'(16'(geo_r.ady * geo_r.ady));
    sq_nxt[0].q      = '0;
    sq_nxt[0].rem    = '0;
    for (int k = 0; k < SQ_STEPS; k++) begin
      // radicand is s scaled by 2^16
      v = {1'b0, sq_r[k].s, 16'b0};
      sq_nxt[k+1] = sqrt_step(sq_r[k], v[33-2*k -: 2]);
    end
  end

  // ---------------- mask stage ----------------
  always_comb begin
    logic [17:0] d, base, diff;
    logic [8:0]  cov;
    logic [16:0] scaled;
    d    = {1'b0, sq_r[SQ_STEPS].q} + 18'(sq_r[SQ_STEPS].rem > {1'b0, sq_r[SQ_STEPS].q});
    base = {2'b0, corner_radius_r, 8'h80};
    diff = base - d;
    if (d >= base) begin
      cov = '0;
    end else if (diff > 18'd256) begin
      cov = 9'd256;
    end else begin
      cov = diff[8:0];
    end
    scaled       = 17'(cov) * 17'd255 + 17'd128;
    mk_nxt.pix   = sq_r[SQ_STEPS].pix;
    mk_nxt.mask  = scaled[15:8];
    mk_nxt.limit = sq_r[SQ_STEPS].corner && (sq_r[SQ_STEPS].pix.alpha > scaled[15:8]);
    mk_nxt.zero  = (scaled[15:8] == '0);
  end

  // ---------------- numerator and divide stages ----------------
  always_comb begin
    logic [15:0] rnd;
    rnd = 16'(mk_r.pix.alpha >> 1);
    dv_nxt[0].info   = mk_r;
    dv_nxt[0].acc[0] = 16'(mk_r.pix.blue  * mk_r.mask) + rnd;
    dv_nxt[0].acc[1] = 16'(mk_r.pix.green * mk_r.mask) + rnd;
    dv_nxt[0].acc[2] = 16'(mk_r.pix.red   * mk_r.mask) + rnd;
    for (int k = 1; k < DV_STG; k++) begin
      dv_nxt[k].info = dv_r[k-1].info;
      for (int c = 0; c < 3; c++) begin
        dv_nxt[k].acc[c] = div_step(dv_r[k-1].acc[c], dv_r[k-1].info.pix.alpha);
      end
    end
  end

  // last divide step and the pass / clear / rescale choice
  always_comb begin
    logic [2:0][15:0] fin;
    mk_t              inf;
    inf = dv_r[DV_STG-1].info;
    for (int c = 0; c < 3; c++) begin
      fin[c] = div_step(dv_r[DV_STG-1].acc[c], inf.pix.alpha);
    end
    if (!inf.limit) begin
      out_nxt = inf.pix;
    end else if (inf.zero) begin
      out_nxt = '0;
    end else begin
      out_nxt.blue  = fin[0][7:0];
      out_nxt.green = fin[1][7:0];
      out_nxt.red   = fin[2][7:0];
      out_nxt.alpha = inf.mask;
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_vld_r <= 1'b0;
      sq_vld_r  <= '0;
      mk_vld_r  <= 1'b0;
      dv_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      geo_vld_r <= in_tvalid;
      sq_vld_r  <= {sq_vld_r[SQ_STEPS-1:0], geo_vld_r};
      mk_vld_r  <= sq_vld_r[SQ_STEPS];
      dv_vld_r  <= {dv_vld_r[DV_STG-2:0], mk_vld_r};
      out_vld_r <= dv_vld_r[DV_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r <= geo_nxt;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      mk_r <= mk_nxt;
      for (int k = 0; k < DV_STG; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // ---------------- assertions ----------------
  assign vld_all  = {geo_vld_r, sq_vld_r, mk_vld_r, dv_vld_r, out_vld_r};
  assign root_ok  = sq_r[SQ_STEPS].q <= 17'(SQ_MAX);
  assign div_fits = (dv_r[0].acc[0][15:8] < dv_r[0].info.pix.alpha) &&
                    (dv_r[0].acc[1][15:8] < dv_r[0].info.pix.alpha) &&
                    (dv_r[0].acc[2][15:8] < dv_r[0].info.pix.alpha);

  `RCAM_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, geo_vld_r, "transfer lost at entry")
  `RCAM_ASSERT_NEXT(a_stall_freezes, out_tvalid && !out_tready, $stable(vld_all), "stage moved")
  `RCAM_ASSERT_NOW(a_root_bound, sq_vld_r[SQ_STEPS], root_ok, "root out of range")
  `RCAM_ASSERT_NOW(a_div_start, dv_vld_r[0] && dv_r[0].info.limit, div_fits, "quotient too wide")

endmodule

// File: tb/sv/rounded_corner_alpha_mask_test.sv
// Self-checking testbench for the rounded corner alpha mask pixel stream
module rounded_corner_alpha_mask_test
  import rcam_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_SETTINGS   = 10;
  localparam int          ITEMS_PER_SET  = 80;
  localparam int          DRAIN_CYCLES   = 40;   // pipeline is 29 deep
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  REG_SPARE      = 2'd3; // unmapped index, write is dropped

  typedef struct {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    pix_t             pix;
  } pixel_item_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [55:0]       in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_addr   = '0;
  logic [DIM_W-1:0]  cfg_wdata  = '0;

  // register shadow used by the prediction
  int          cur_width  = 420;
  int          cur_height = 420;
  int          cur_radius = 24;

  pixel_item_t pixel_q[$];   // pixels waiting to be driven
  pix_t        masked_q[$];  // predicted output pixels, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit in_taken      = 1'b0;
  int fail_cnt      = 0;
  int out_cnt       = 0;
  int masked_cnt    = 0;
  int idle_cycles   = 0;

  rounded_corner_alpha_mask dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Q8 distance to the circle centre -> 0..255 mask alpha
  function automatic int corner_mask_alpha(int dx, int dy, int r);
    longint v, root, trial, cov;
    v = longint'(dx * dx + dy * dy) * 65536;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    if (v - root * root > root) root++;
    cov = longint'(r) * 256 + 128 - root;
    if (cov < 0) cov = 0;
    if (cov > 256) cov = 256;
    return int'((cov * 255 + 128) >>> 8);
  endfunction

  function automatic pix_t masked_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                        pix_t pin);
    int   w, h, r, half, edge_len, xi, yi, dx, dy, m, a;
    logic at_left, at_right, at_top, at_bottom;
    pix_t res;
    res = pin;
    w  = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
    h  = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
    r  = cur_radius;
    xi = px;
    yi = py;
    if (w < 2 || h < 2 || xi >= w || yi >= h) return res;
    half     = ((w < h) ? w : h) / 2;
    edge_len = (r + 2 < half) ? r + 2 : half;
    at_left   = xi < edge_len;
    at_right  = xi >= w - edge_len;
    at_top    = yi < edge_len;
    at_bottom = yi >= h - edge_len;
    if (!((at_left || at_right) && (at_top || at_bottom))) return res;
    dx = at_left ? xi - r : xi + 1 - w + r;
    dy = at_top  ? yi - r : yi + 1 - h + r;
    m  = corner_mask_alpha(dx, dy, r);
    a  = pin.alpha;
    if (a > m) begin
      if (m == 0) begin
        res = '0;
      end else begin
        res.blue  = CH_W'((int'(pin.blue)  * m + a / 2) / a);
        res.green = CH_W'((int'(pin.green) * m + a / 2) / a);
        res.red   = CH_W'((int'(pin.red)   * m + a / 2) / a);
        res.alpha = CH_W'(m);
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("  @%0t %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // input side: pop a new pixel once the current one has transferred
  always @(negedge clk) begin : pixel_driver
    pixel_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.pix, nxt.pos_y, nxt.pos_x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : input_predict
    pix_t pin, want;
    if (rst_n && in_tvalid && in_tready) begin
      pin  = pix_t'(in_tdata[55:24]);
      want = masked_pixel(in_tdata[11:0], in_tdata[23:12], pin);
      masked_q.push_back(want);
      if (want != pin) masked_cnt++;
      in_taken = 1'b1;
    end
  end

  always @(posedge clk) begin : output_check
    pix_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = pix_t'(out_tdata);
      out_cnt++;
      if (masked_q.size() == 0) begin
        note_mismatch("output transfer with nothing pending (alpha)", 0, got.alpha);
      end else begin
        want = masked_q.pop_front();
        if (got.blue  !== want.blue)  note_mismatch("out_blue",  want.blue,  got.blue);
        if (got.green !== want.green) note_mismatch("out_green", want.green, got.green);
        if (got.red   !== want.red)   note_mismatch("out_red",   want.red,   got.red);
        if (got.alpha !== want.alpha) note_mismatch("out_alpha", want.alpha, got.alpha);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Stream stalled for %0d cycles, %0d results outstanding",
                 idle_cycles, masked_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= DIM_W'(val);
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:   cur_width  = val & 13'h1FFF;
      REG_FRAME_HEIGHT:  cur_height = val & 13'h1FFF;
      REG_CORNER_RADIUS: cur_radius = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic push_pixel(int x, int y, int b, int g, int r, int a);
    pixel_item_t it;
    it.pos_x     = POS_W'(x);
    it.pos_y     = POS_W'(y);
    it.pix.blue  = CH_W'(b);
    it.pix.green = CH_W'(g);
    it.pix.red   = CH_W'(r);
    it.pix.alpha = CH_W'(a);
    pixel_q.push_back(it);
  endtask

  // mostly corner-box pixels, some near the frame border, some anywhere
  task automatic push_random_pixel();
    int w, h, half, edge_len, ox, oy, x, y, a, b, g, r, pick;
    w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
    h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
    half     = ((w < h) ? w : h) / 2;
    edge_len = (cur_radius + 2 < half) ? cur_radius + 2 : half;
    pick = $urandom_range(99);
    if (pick < 65 && w >= 2 && h >= 2) begin
      ox = $urandom_range(edge_len + 1);
      oy = $urandom_range(edge_len + 1);
      if (ox > w - 1) ox = w - 1;
      if (oy > h - 1) oy = h - 1;
      x = $urandom_range(1) ? ox : w - 1 - ox;
      y = $urandom_range(1) ? oy : h - 1 - oy;
    end else if (pick < 80) begin
      if ($urandom_range(1)) begin
        x = w - 2 + $urandom_range(3);
        y = $urandom_range(h);
      end else begin
        x = $urandom_range(w);
        y = h - 2 + $urandom_range(3);
      end
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        a = $urandom_range(255);
        b = $urandom_range(a);
        g = $urandom_range(a);
        r = $urandom_range(a);
      end
      8: begin
        a = 255; b = 255; g = 255; r = 255;
      end
      9: begin
        a = $urandom_range(255);
        b = $urandom_range(1) * 255;
        g = $urandom_range(1) * 255;
        r = $urandom_range(1) * 255;
      end
      default: begin
        a = $urandom_range(255);
        b = $urandom_range(255);
        g = $urandom_range(255);
        r = $urandom_range(255);
      end
    endcase
    push_pixel(x, y, b, g, r, a);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || masked_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int set_w [NUM_SETTINGS];
    int set_h [NUM_SETTINGS];
    int set_r [NUM_SETTINGS];
    set_w = '{420, 4096, 2, 8191, 1, 640, 37, 100, 0, 0};
    set_h = '{420, 4096, 2, 300, 100, 0, 1000, 64, 0, 0};
    set_r = '{24, 255, 0, 200, 10, 50, 255, 7, 0, 0};
    for (int i = 8; i < NUM_SETTINGS; i++) begin
      set_w[i] = $urandom_range(4096, 2);
      set_h[i] = $urandom_range(4096, 2);
      set_r[i] = $urandom_range(255);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 420x420, radius 24, corner box side 26
    push_pixel(0, 0, 200, 100, 50, 255);       // far outside the arc: cleared
    push_pixel(419, 0, 10, 20, 30, 40);
    push_pixel(0, 419, 40, 30, 20, 10);
    push_pixel(419, 419, 255, 255, 255, 255);
    push_pixel(24, 24, 255, 255, 255, 255);    // circle centre, full mask
    push_pixel(7, 7, 100, 80, 60, 200);        // on the antialiased rim
    push_pixel(24, 0, 255, 255, 255, 255);     // mask rounds up from half
    push_pixel(25, 25, 90, 90, 90, 180);
    push_pixel(26, 0, 10, 20, 30, 255);        // just right of the box
    push_pixel(0, 26, 10, 20, 30, 255);        // just below the box
    push_pixel(394, 394, 120, 60, 30, 250);
    push_pixel(7, 7, 255, 255, 255, 128);      // colour above alpha
    push_pixel(7, 7, 0, 0, 0, 117);            // alpha equals mask
    push_pixel(7, 7, 1, 1, 1, 118);            // alpha one above mask
    push_pixel(7, 7, 0, 0, 0, 0);
    push_pixel(420, 0, 1, 2, 3, 255);          // right of the frame
    push_pixel(0, 420, 3, 2, 1, 255);          // below the frame
    push_pixel(4095, 4095, 255, 255, 255, 255);
    push_pixel(0, 0, 0, 0, 0, 0);
    push_pixel(2730, 1365, 170, 85, 170, 85);
    push_pixel(412, 5, 170, 85, 170, 200);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s != 0) begin
        wait_drained();
        write_reg(REG_FRAME_WIDTH, set_w[s]);
        write_reg(REG_FRAME_HEIGHT, set_h[s]);
        write_reg(REG_CORNER_RADIUS, set_r[s]);
        write_reg(REG_SPARE, $urandom_range(8191));
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      case (s % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (int n = 0; n < ITEMS_PER_SET; n++) push_random_pixel();
    end

    wait_drained();
    if (masked_q.size() != 0) fail_cnt += masked_q.size();

    $display("Checked %0d output pixels over %0d frame/radius settings,", out_cnt,
             NUM_SETTINGS);
    $display("%0d of them reshaped by a corner, under mixed source gaps and sink stalls.",
             masked_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rcam_pkg.sv
src/rounded_corner_alpha_mask.sv
tb/sv/rounded_corner_alpha_mask_test.sv
